FILE: rtl/core/bpk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpk_pkg
// Shared types and constants of the MSB-first bit packer.
// ----------------------------------------------------------------------------
package bpk_pkg;

   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned WIDTH_W   = 6;
   localparam int unsigned HOLD_W    = 7;
   localparam int unsigned ACC_W     = VALUE_W + HOLD_W;
   localparam int unsigned WORD_W    = ACC_W + 1;
   localparam int unsigned COUNT_W   = 3;
   localparam int unsigned BYTE_W    = 8;
   localparam logic [WIDTH_W-1:0] FIELD_WIDTH_RESET = 6'd8;

   // One queued job: bits left aligned, earliest bit in the top position.
   typedef struct packed {
      logic [WORD_W-1:0]  word;
      logic [COUNT_W-1:0] count;
      logic               last;
   } job_type;

endpackage : bpk_pkg
`default_nettype wire

FILE: rtl/core/bpk_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpk_front
// Accepts values, merges them behind the held remainder and queues the
// resulting byte job.
// ----------------------------------------------------------------------------
module bpk_front
   import bpk_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [WIDTH_W-1:0]  csr_data,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [VALUE_W-1:0]  req_value,
   input  wire logic                req_last,
   input  wire logic                q_ready,
   output logic                     q_push,
   output job_type                  q_job
);

   localparam int unsigned LIMIT = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;

   logic [WIDTH_W-1:0] field_width_ff, field_width_in;
   logic [HOLD_W-1:0]  pend_bits_ff, pend_bits_in;
   logic [2:0]         pend_count_ff, pend_count_in;

   logic [WIDTH_W-1:0] w;
   logic [VALUE_W-1:0] val;
   logic [WIDTH_W-1:0] total;
   logic [ACC_W-1:0]   acc;
   logic [2:0]         rem;
   logic               flush;
   logic               accept;

   assign csr_ready  = 1'b1;
   assign req_tready = q_ready;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      w = (field_width_ff > WIDTH_W'(LIMIT)) ? WIDTH_W'(LIMIT) : field_width_ff;
      val   = req_value & ~({VALUE_W{1'b1}} << w);
      total = {3'b000, pend_count_ff} + w;
      acc   = ({{VALUE_W{1'b0}}, pend_bits_ff} << w) | {{HOLD_W{1'b0}}, val};
      rem   = total[2:0];
      flush = req_last & (rem != 3'd0);
      q_job.word  = {1'b0, acc} << (WIDTH_W'(WORD_W) - total);
      q_job.count = total[5:3] + {2'b00, flush};
      q_job.last  = req_last;
      q_push      = accept & (q_job.count != '0);
   end

   always_comb begin
      field_width_in = field_width_ff;
      pend_bits_in   = pend_bits_ff;
      pend_count_in  = pend_count_ff;
      if (csr_valid && csr_ready) begin
         field_width_in = csr_data;
      end
      if (accept) begin
         if (req_last) begin
            pend_bits_in  = '0;
            pend_count_in = '0;
         end else begin
            pend_bits_in  = acc[HOLD_W-1:0] & (7'h7F >> (3'd7 - rem));
            pend_count_in = rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_width_ff <= FIELD_WIDTH_RESET;
         pend_bits_ff   <= '0;
         pend_count_ff  <= '0;
      end else begin
         field_width_ff <= field_width_in;
         pend_bits_ff   <= pend_bits_in;
         pend_count_ff  <= pend_count_in;
      end
   end

endmodule : bpk_front
`default_nettype wire

FILE: rtl/core/bpk_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpk_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module bpk_queue
   import bpk_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         ready,
   input  wire logic    pop,
   output logic         valid,
   output job_type      head
);

   job_type    mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign ready = (count_ff != 2'd2);
   assign valid = (count_ff != 2'd0);
   assign head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule : bpk_queue
`default_nettype wire

FILE: rtl/core/bpk_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpk_back
// Drains queued jobs to the output register, one byte per unstalled cycle.
// ----------------------------------------------------------------------------
module bpk_back
   import bpk_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire job_type            q_head,
   output logic                    q_pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [BYTE_W-1:0]       rsp_byte,
   output logic                    rsp_run_end,
   output logic                    rsp_stream_end
);

   logic               busy_ff, busy_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic               last_ff, last_in;
   logic               out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic               out_eor_ff, out_eor_in;
   logic               out_eos_ff, out_eos_in;
   logic               load_out;
   logic               emit_final;

   assign load_out   = !out_valid_ff || rsp_tready;
   assign emit_final = busy_ff && load_out && (left_ff == COUNT_W'(1));
   assign q_pop      = q_valid && (!busy_ff || emit_final);

   assign rsp_tvalid     = out_valid_ff;
   assign rsp_byte       = out_byte_ff;
   assign rsp_run_end    = out_eor_ff;
   assign rsp_stream_end = out_eos_ff;

   always_comb begin
      busy_in      = busy_ff;
      word_in      = word_ff;
      left_in      = left_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_byte_in  = out_byte_ff;
      out_eor_in   = out_eor_ff;
      out_eos_in   = out_eos_ff;
      if (busy_ff && load_out) begin
         out_valid_in = 1'b1;
         out_byte_in  = word_ff[WORD_W-1 -: BYTE_W];
         out_eor_in   = (left_ff == COUNT_W'(1));
         out_eos_in   = (left_ff == COUNT_W'(1)) && last_ff;
         word_in      = word_ff << BYTE_W;
         left_in      = left_ff - COUNT_W'(1);
         if (left_ff == COUNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
      if (q_pop) begin
         busy_in = 1'b1;
         word_in = q_head.word;
         left_in = q_head.count;
         last_in = q_head.last;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      left_ff     <= left_in;
      last_ff     <= last_in;
      out_byte_ff <= out_byte_in;
      out_eor_ff  <= out_eor_in;
      out_eos_ff  <= out_eos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // The stream end mark only ever sits on the final byte of a job.
   a_eos_on_run_end : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_eos_ff |-> out_eor_ff)
      else $error("stream end without run end");

   // A job in progress always has bytes left to send.
   a_busy_has_bytes : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (left_ff != '0))
      else $error("busy with no bytes left");

   // Sending the final byte with nothing queued leaves the back part idle.
   a_idle_after_final : assert property (@(posedge clock) disable iff (reset)
      emit_final && !q_pop |=> !busy_ff)
      else $error("still busy after final byte");

endmodule : bpk_back
`default_nettype wire

FILE: rtl/core/msb_first_bit_packer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msb_first_bit_packer_core
// Packs the low field_width bits of each value MSB first into bytes.
// ----------------------------------------------------------------------------
// Path: a value's bytes pass the job queue, job word and output register.
// Throughput: one value per cycle accepted into the 2-entry job queue while
// it has room; the back part drains one byte per cycle while rsp_tready
// allows, and a value yields n (0..5) bytes.
// Reset: synchronous; clears remainder, queue and output, field_width = 8.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_core
   import bpk_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [WIDTH_W-1:0] csr_data,    // field_width
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [31:0]        req_tdata,   // [31:0] value
   input  wire logic               req_tlast,   // last_value
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [7:0]              rsp_tdata,   // [7:0] packed_byte
   output logic                    rsp_tlast,   // end_of_run
   output logic                    rsp_tuser    // end_of_stream
);

   job_type push_job;
   job_type head_job;
   logic    q_push;
   logic    q_ready;
   logic    q_pop;
   logic    q_valid;

   bpk_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_value  (req_tdata),
      .req_last   (req_tlast),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   bpk_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .ready    (q_ready),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (head_job)
   );

   bpk_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_head         (head_job),
      .q_pop          (q_pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_byte       (rsp_tdata),
      .rsp_run_end    (rsp_tlast),
      .rsp_stream_end (rsp_tuser)
   );

endmodule : msb_first_bit_packer_core
`default_nettype wire
